@@ sv/kdlp_pkg.sv @@
package kdlp_pkg;

    // Fixed widths of the fields and configuration registers.
    localparam int KEY_W        = 16;
    localparam int KEY_COUNT_W  = 5;
    localparam int TICKS_W      = 15;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Defaults of the top-level parameters.
    localparam int NUM_KEYS_DEF     = 16;
    localparam int HISTORY_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF   = 32;

    // Reset values of the configuration registers.
    localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST    = KEY_COUNT_W'(16);
    localparam logic [KEY_W-1:0]       TRIG_MASK_RST    = '0;
    localparam logic [TICKS_W-1:0]     LONG_THRESH_RST  = TICKS_W'(500);
    localparam logic [TICKS_W-1:0]     REPEAT_SPAN_RST  = TICKS_W'(100);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_COUNT   = 2'd0,
        CFG_TRIG_MASK   = 2'd1,
        CFG_LONG_THRESH = 2'd2,
        CFG_REPEAT_SPAN = 2'd3
    } t_cfg_reg;

    // Shared timing settings that every lane sees.
    typedef struct packed {
        logic [TICKS_W-1:0] long_thresh;
        logic [TICKS_W-1:0] repeat_span;
    } t_lane_cfg;

    // What one lane reports for the current beat.
    typedef struct packed {
        logic press;
        logic long_press;
        logic held;
    } t_lane_flags;

endpackage

@@ sv/kdlp_in_if.sv @@
interface kdlp_in_if;
    import kdlp_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

@@ sv/kdlp_out_if.sv @@
interface kdlp_out_if;
    import kdlp_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] press_events;
    logic [KEY_W-1:0] long_events;
    logic [KEY_W-1:0] held_keys;

    modport source (output valid, output press_events, output long_events,
                    output held_keys, input ready);
    modport sink   (input valid, input press_events, input long_events,
                    input held_keys, output ready);
endinterface

@@ sv/kdlp_lane.sv @@
module kdlp_lane #(
    parameter int HISTORY_BITS = kdlp_pkg::HISTORY_BITS_DEF,
    parameter int COUNT_BITS   = kdlp_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_level,
    input  logic                  i_trig,
    input  kdlp_pkg::t_lane_cfg   i_cfg,
    output kdlp_pkg::t_lane_flags o_flags
);
    import kdlp_pkg::*;

    logic [HISTORY_BITS-1:0] r_hist;
    logic                    r_released;
    logic [COUNT_BITS-1:0]   r_held;
    logic [COUNT_BITS-1:0]   r_thresh;

    logic [HISTORY_BITS-1:0] n_hist;
    logic                    n_released;
    logic [COUNT_BITS-1:0]   n_held;
    logic [COUNT_BITS-1:0]   n_thresh;

    logic                    w_sample;
    logic                    w_long;
    logic [COUNT_BITS:0]     w_sum;

    always_comb begin
        w_sample   = ~(i_level ^ i_trig);
        n_hist     = {r_hist[HISTORY_BITS-2:0], w_sample};
        n_released = r_released;
        n_held     = r_held;
        if (&n_hist) begin
            n_released = 1'b0;
            if (~&r_held) begin
                n_held = r_held + COUNT_BITS'(1);
            end
        end else if (~|n_hist) begin
            n_released = 1'b1;
            n_held     = '0;
        end

        // The threshold moves up by the repeat span each time it is reached.
        w_sum    = {1'b0, r_thresh} + (COUNT_BITS+1)'(i_cfg.repeat_span);
        n_thresh = r_thresh;
        w_long   = 1'b0;
        if (|n_held) begin
            if (n_held >= r_thresh) begin
                w_long   = 1'b1;
                n_thresh = w_sum[COUNT_BITS] ? '1 : w_sum[COUNT_BITS-1:0];
            end
        end else begin
            n_thresh = COUNT_BITS'(i_cfg.long_thresh);
        end

        o_flags.press      = i_en & r_released & ~n_released;
        o_flags.long_press = i_en & w_long;
        o_flags.held       = i_en & ~n_released;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_released <= 1'b1;
            r_held     <= '0;
            r_thresh   <= '0;
        end else if (i_en) begin
            r_hist     <= n_hist;
            r_released <= n_released;
            r_held     <= n_held;
            r_thresh   <= n_thresh;
        end
    end

endmodule

@@ sv/kdlp_merge.sv @@
module kdlp_merge #(
    parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  kdlp_pkg::t_lane_flags i_flags [NUM_KEYS],
    output logic                  o_free,
    kdlp_out_if.source            o_evt
);
    import kdlp_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_press;
    logic [KEY_W-1:0] r_long;
    logic [KEY_W-1:0] r_held;

    logic [KEY_W-1:0] n_press;
    logic [KEY_W-1:0] n_long;
    logic [KEY_W-1:0] n_held;

    // The output register can take a new beat when empty or being drained.
    assign o_free = ~r_valid | o_evt.ready;

    always_comb begin
        n_press = '0;
        n_long  = '0;
        n_held  = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_press[k] = i_flags[k].press;
            n_long[k]  = i_flags[k].long_press;
            n_held[k]  = i_flags[k].held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_press <= n_press;
            r_long  <= n_long;
            r_held  <= n_held;
        end
    end

    assign o_evt.valid        = r_valid;
    assign o_evt.press_events = r_press;
    assign o_evt.long_events  = r_long;
    assign o_evt.held_keys    = r_held;

endmodule

@@ sv/key_debounce_long_press.sv @@
// Key debouncer with long-press repeat. Each input beat is one scan tick with
// the raw levels of up to 16 keys; every key has its own lane that shifts the
// level into a history register, declares the key pressed on a history of all
// ones and released on all zeros, counts held ticks and flags a long press
// each time the count reaches a threshold that then moves up by the repeat
// span. One beat is taken every clock cycle while the output register is free:
// all enabled lanes update their state in the cycle the beat is accepted, and
// the result beat appears in the output register on the next cycle. A new tick
// is accepted while the previous result waits, as long as the output register
// is drained in the same cycle. Keys at or above key_count keep their state and
// read as zero. Configuration writes take effect at once and must be made while
// idle.
module key_debounce_long_press #(
    parameter int NUM_KEYS     = kdlp_pkg::NUM_KEYS_DEF,
    parameter int HISTORY_BITS = kdlp_pkg::HISTORY_BITS_DEF,
    parameter int COUNT_BITS   = kdlp_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kdlp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    kdlp_in_if.sink                            i_key,
    kdlp_out_if.source                         o_evt
);
    import kdlp_pkg::*;

    logic [KEY_COUNT_W-1:0] r_key_count;
    logic [KEY_W-1:0]       r_trig_mask;
    logic [TICKS_W-1:0]     r_long_thresh;
    logic [TICKS_W-1:0]     r_repeat_span;

    logic        w_free;
    logic        w_accept;
    t_lane_cfg   w_cfg;
    t_lane_flags w_flags [NUM_KEYS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count   <= KEY_COUNT_RST;
            r_trig_mask   <= TRIG_MASK_RST;
            r_long_thresh <= LONG_THRESH_RST;
            r_repeat_span <= REPEAT_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_KEY_COUNT:   r_key_count   <= i_cfg_data[KEY_COUNT_W-1:0];
                CFG_TRIG_MASK:   r_trig_mask   <= i_cfg_data[KEY_W-1:0];
                CFG_LONG_THRESH: r_long_thresh <= i_cfg_data[TICKS_W-1:0];
                CFG_REPEAT_SPAN: r_repeat_span <= i_cfg_data[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.long_thresh = r_long_thresh;
    assign w_cfg.repeat_span = r_repeat_span;

    assign i_key.ready = w_free;
    assign w_accept    = i_key.valid & w_free;

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        kdlp_lane #(
            .HISTORY_BITS (HISTORY_BITS),
            .COUNT_BITS   (COUNT_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept & (r_key_count > KEY_COUNT_W'(g))),
            .i_level (i_key.raw_levels[g]),
            .i_trig  (r_trig_mask[g]),
            .i_cfg   (w_cfg),
            .o_flags (w_flags[g])
        );
    end

    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_key.valid),
        .i_flags (w_flags),
        .o_free  (w_free),
        .o_evt   (o_evt)
    );

endmodule
